@@ hw/rtl/prt_pkg.sv @@
package prt_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int MAX_ACTIONS = 16;
   localparam int ACT_W       = $clog2(MAX_ACTIONS);
   localparam int MAX_STATES  = 1024;
   localparam int STATE_W     = $clog2(MAX_STATES);
   localparam int MOD_W       = STATE_W + 1;
   localparam int ADDR_W      = 64;
   localparam int PC_W        = 64;
   localparam int REWARD_W    = 16;
   localparam int LIMIT_W     = 6;

   // remainder unit: 32 dividend bits, 8 per cycle
   localparam int DVD_W       = 32;
   localparam int DIV_BITS    = 8;
   localparam int DIV_STEPS   = DVD_W / DIV_BITS;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TABLE_LIMIT = 3'd0,
      CSR_STATE_MODE  = 3'd1,
      CSR_STATE_COUNT = 3'd2,
      CSR_REWARD_HIT  = 3'd3,
      CSR_REWARD_MISS = 3'd4
   } csr_index_type;

   localparam logic KIND_DEMAND = 1'b0;
   localparam logic KIND_TRACK  = 1'b1;

   typedef struct packed {
      logic capture;   // take request word, start remainder unit
      logic search;    // compare address against held entries
      logic commit;    // update table, load response register
   } cmd_type;

   typedef struct packed {
      logic div_last;  // remainder unit in its final step
      logic out_free;  // response register can take a word
   } status_type;

endpackage

@@ hw/rtl/prt_mod_unit.sv @@
module prt_mod_unit
   import prt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DVD_W-1:0]   dividend,
   input  logic [MOD_W-1:0]   modulus,
   output logic               last,
   output logic [STATE_W-1:0] remainder
);

   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [STATE_W-1:0]   rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;

   // restoring remainder, DIV_BITS bits per cycle
   always_comb begin
      logic [MOD_W-1:0] r;
      logic [DVD_W-1:0] d;
      r = {1'b0, rem_ff};
      d = dvd_ff;
      for (int k = 0; k < DIV_BITS; k++) begin
         r = {r[STATE_W-1:0], d[DVD_W-1]};
         d = {d[DVD_W-2:0], 1'b0};
         if (r >= modulus) begin
            r = r - modulus;
         end
      end
      rem_in = r[STATE_W-1:0];
      dvd_in = d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   assign last      = busy_ff && (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign remainder = rem_ff;

endmodule

@@ hw/rtl/prt_dpath.sv @@
module prt_dpath
   import prt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  req_kind,
   input  logic [ADDR_W-1:0]     req_address,
   input  logic [PC_W-1:0]       req_pc,
   input  logic [ACT_W-1:0]      req_action_index,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_tracker_hit,
   output logic                  rsp_train_valid,
   output logic [STATE_W-1:0]    rsp_train_state_old,
   output logic [ACT_W-1:0]      rsp_train_action_old,
   output logic signed [REWARD_W-1:0] rsp_train_reward_old,
   output logic [STATE_W-1:0]    rsp_train_state_new,
   output logic [ACT_W-1:0]      rsp_train_action_new
);

   // configuration
   logic [LIMIT_W-1:0]  cfg_limit_ff;
   logic                cfg_mode_ff;
   logic [MOD_W-1:0]    cfg_count_ff;
   logic [REWARD_W-1:0] cfg_hit_ff;
   logic [REWARD_W-1:0] cfg_miss_ff;

   // captured request
   logic                kind_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [ACT_W-1:0]    act_ff;

   // table
   logic [ADDR_W-1:0]   ent_addr_ff    [TABLE_DEPTH];
   logic [STATE_W-1:0]  ent_state_ff   [TABLE_DEPTH];
   logic [ACT_W-1:0]    ent_action_ff  [TABLE_DEPTH];
   logic [REWARD_W-1:0] ent_reward_ff  [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] ent_rewarded_ff;
   logic [IDX_W-1:0]    head_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [TABLE_DEPTH-1:0] match_ff, match_in;

   // last evicted entry
   logic                victim_valid_ff;
   logic [STATE_W-1:0]  victim_state_ff;
   logic [ACT_W-1:0]    victim_action_ff;
   logic                victim_rewarded_ff;
   logic [REWARD_W-1:0] victim_reward_ff;

   // response register
   logic                rsp_valid_ff;
   logic                rsp_hit_ff, rsp_tv_ff;
   logic [STATE_W-1:0]  rsp_so_ff, rsp_sn_ff;
   logic [ACT_W-1:0]    rsp_ao_ff, rsp_an_ff;
   logic [REWARD_W-1:0] rsp_ro_ff;

   logic [MOD_W-1:0]    modulus;
   logic                div_last;
   logic [STATE_W-1:0]  remainder;
   logic [STATE_W-1:0]  new_state;
   logic                hit;
   logic [IDX_W-1:0]    hit_slot;
   logic [CNT_W-1:0]    limit;
   logic                evict;
   logic                emit;
   logic [IDX_W-1:0]    ins_slot;
   logic [REWARD_W-1:0] old_reward;

   always_comb begin
      if (cfg_count_ff == '0) begin
         modulus = MOD_W'(1);
      end else if (cfg_count_ff > MOD_W'(MAX_STATES)) begin
         modulus = MOD_W'(MAX_STATES);
      end else begin
         modulus = cfg_count_ff;
      end
   end

   prt_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.capture),
      .dividend  (req_pc[DVD_W-1:0]),
      .modulus   (modulus),
      .last      (div_last),
      .remainder (remainder)
   );

   // parallel compare against held slots
   always_comb begin
      logic [IDX_W-1:0] off;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         off = IDX_W'(i) - head_ff;
         match_in[i] = ({1'b0, off} < count_ff) && (ent_addr_ff[i] == addr_ff);
      end
   end

   // held addresses are unique, so the match vector is one-hot or empty
   always_comb begin
      hit_slot = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (match_ff[i]) begin
            hit_slot = hit_slot | IDX_W'(i);
         end
      end
   end

   always_comb begin
      if (cfg_limit_ff == '0) begin
         limit = CNT_W'(1);
      end else if (CNT_W'(cfg_limit_ff) > CNT_W'(TABLE_DEPTH)) begin
         limit = CNT_W'(TABLE_DEPTH);
      end else begin
         limit = CNT_W'(cfg_limit_ff);
      end
   end

   assign hit        = |match_ff;
   assign evict      = (kind_ff == KIND_TRACK) && !hit && (count_ff >= limit);
   assign emit       = evict && victim_valid_ff;
   assign ins_slot   = head_ff + count_ff[IDX_W-1:0];
   assign new_state  = cfg_mode_ff ? remainder : '0;
   assign old_reward = victim_rewarded_ff ? victim_reward_ff : cfg_miss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_limit_ff <= LIMIT_W'(TABLE_DEPTH);
         cfg_mode_ff  <= 1'b1;
         cfg_count_ff <= MOD_W'(MAX_STATES);
         cfg_hit_ff   <= REWARD_W'(1);
         cfg_miss_ff  <= '1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TABLE_LIMIT: cfg_limit_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_STATE_MODE:  cfg_mode_ff  <= csr_wdata[0];
            CSR_STATE_COUNT: cfg_count_ff <= csr_wdata[MOD_W-1:0];
            CSR_REWARD_HIT:  cfg_hit_ff   <= csr_wdata[REWARD_W-1:0];
            CSR_REWARD_MISS: cfg_miss_ff  <= csr_wdata[REWARD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         addr_ff <= req_address;
         act_ff  <= req_action_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= '0;
      end else if (cmd.search) begin
         match_ff <= match_in;
      end
   end

   // table payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (kind_ff == KIND_DEMAND) begin
            if (hit && !ent_rewarded_ff[hit_slot]) begin
               ent_reward_ff[hit_slot] <= cfg_hit_ff;
            end
         end else if (!hit) begin
            ent_addr_ff[ins_slot]   <= addr_ff;
            ent_state_ff[ins_slot]  <= new_state;
            ent_action_ff[ins_slot] <= act_ff;
         end
      end
   end

   // table control and victim
   always_ff @(posedge clock) begin
      if (reset) begin
         ent_rewarded_ff    <= '0;
         head_ff            <= '0;
         count_ff           <= '0;
         victim_valid_ff    <= 1'b0;
         victim_state_ff    <= '0;
         victim_action_ff   <= '0;
         victim_rewarded_ff <= 1'b0;
         victim_reward_ff   <= '0;
      end else if (cmd.commit) begin
         if (kind_ff == KIND_DEMAND) begin
            if (hit) begin
               ent_rewarded_ff[hit_slot] <= 1'b1;
            end
         end else if (!hit) begin
            ent_rewarded_ff[ins_slot] <= 1'b0;
            if (evict) begin
               victim_valid_ff    <= 1'b1;
               victim_state_ff    <= ent_state_ff[head_ff];
               victim_action_ff   <= ent_action_ff[head_ff];
               victim_rewarded_ff <= ent_rewarded_ff[head_ff];
               victim_reward_ff   <= ent_rewarded_ff[head_ff] ? ent_reward_ff[head_ff] : '0;
               head_ff            <= head_ff + 1'b1;
            end else begin
               count_ff <= count_ff + 1'b1;
            end
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff <= hit;
         rsp_tv_ff  <= emit;
         rsp_so_ff  <= emit ? victim_state_ff : '0;
         rsp_ao_ff  <= emit ? victim_action_ff : '0;
         rsp_ro_ff  <= emit ? old_reward : '0;
         rsp_sn_ff  <= emit ? ent_state_ff[head_ff] : '0;
         rsp_an_ff  <= emit ? ent_action_ff[head_ff] : '0;
      end
   end

   assign status.div_last = div_last;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_tracker_hit      = rsp_hit_ff;
   assign rsp_train_valid      = rsp_tv_ff;
   assign rsp_train_state_old  = rsp_so_ff;
   assign rsp_train_action_old = rsp_ao_ff;
   assign rsp_train_reward_old = rsp_ro_ff;
   assign rsp_train_state_new  = rsp_sn_ff;
   assign rsp_train_action_new = rsp_an_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      $countones(match_ff) <= 1)
      else $error("address held in more than one entry");

   a_train_victim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_tv_ff |-> victim_valid_ff)
      else $error("training word without a victim");
`endif

endmodule

@@ hw/rtl/prt_ctrl.sv @@
module prt_ctrl
   import prt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      IDLE,
      RUN,
      COMMIT
   } state_type;

   state_type state_ff;
   logic      accept;

   assign req_ready   = (state_ff == IDLE) || ((state_ff == COMMIT) && status.out_free);
   assign accept      = req_valid && req_ready;
   assign cmd.capture = accept;
   assign cmd.search  = (state_ff == RUN);
   assign cmd.commit  = (state_ff == COMMIT) && status.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         case (state_ff)
            IDLE: begin
               if (accept) begin
                  state_ff <= RUN;
               end
            end
            RUN: begin
               if (status.div_last) begin
                  state_ff <= COMMIT;
               end
            end
            COMMIT: begin
               if (status.out_free) begin
                  state_ff <= accept ? RUN : IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_commit_after_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == COMMIT |-> $past(state_ff) == RUN || $past(state_ff) == COMMIT)
      else $error("commit entered without a finished remainder");
`endif

endmodule

@@ hw/rtl/prefetch_reward_tracker_top.sv @@
// Each request word is taken, then the remainder unit works through the low 32
// pc bits at 8 bits a cycle while the table is searched, and the table commit
// loads the result word; the commit waits while the response register is still
// held by rsp_ready low. The next request word may be taken in the commit cycle.
// Reset (synchronous, active high): table empty, no victim, response empty,
// configuration back to its defaults.
module prefetch_reward_tracker_top
   import prt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request word
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [ADDR_W-1:0]     req_address,
   input  logic [PC_W-1:0]       req_pc,
   input  logic [ACT_W-1:0]      req_action_index,
   // response word
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_tracker_hit,
   output logic                  rsp_train_valid,
   output logic [STATE_W-1:0]    rsp_train_state_old,
   output logic [ACT_W-1:0]      rsp_train_action_old,
   output logic signed [REWARD_W-1:0] rsp_train_reward_old,
   output logic [STATE_W-1:0]    rsp_train_state_new,
   output logic [ACT_W-1:0]      rsp_train_action_new,
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // The controller sequences each word: take it, search the table while the
   // remainder unit derives the state value, then commit once the response
   // register is free. The next request may be taken in the commit cycle.
   cmd_type    cmd;
   status_type status;

   prt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: FIFO table of tracked addresses (compared in parallel, one
   // registered match vector), victim register, config and response registers.
   prt_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_kind             (req_kind),
      .req_address          (req_address),
      .req_pc               (req_pc),
      .req_action_index     (req_action_index),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_tracker_hit      (rsp_tracker_hit),
      .rsp_train_valid      (rsp_train_valid),
      .rsp_train_state_old  (rsp_train_state_old),
      .rsp_train_action_old (rsp_train_action_old),
      .rsp_train_reward_old (rsp_train_reward_old),
      .rsp_train_state_new  (rsp_train_state_new),
      .rsp_train_action_new (rsp_train_action_new)
   );

endmodule
